// ----- rtl/pfa_pkg.sv -----
// Shared types, codes and constants of the page frame allocator.
`default_nettype none
package pfa_pkg;

  // Default geometry of the store.
  localparam int DEF_MAX_PAGES     = 512;
  localparam int DEF_MAP_WORD_BITS = 32;
  localparam int DEF_REF_BITS      = 8;
  localparam int DEF_QUEUE_DEPTH   = 2;

  // Fixed field widths of the ports.
  localparam int REQ_W      = 2;
  localparam int PAGE_NUM_W = 9;
  localparam int STATUS_W   = 2;
  localparam int REF_OUT_W  = 8;
  localparam int FREE_OUT_W = 10;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 1;

  // Widths inside a command; all are bounded by the 10-bit configuration fields.
  localparam int WORD_IDX_W = 6;
  localparam int BIT_OFS_W  = 6;
  localparam int WORDS_W    = 7;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INIT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INC   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEC   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES    = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESERVED_RESET = 10'd0;
  localparam logic [CFG_W-1:0]     CFG_TOTAL_RESET    = 10'd512;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [PAGE_NUM_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PAGE_NUM_W-1:0] alloc_page;
    logic [REF_OUT_W-1:0]  ref_count;
    logic [FREE_OUT_W-1:0] free_pages;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_ALLOC,
    CMD_INC,
    CMD_DEC,
    CMD_RANGE
  } cmd_op_e;

  // A classified request as the back end consumes it.
  typedef struct packed {
    cmd_op_e               op;
    logic [PAGE_NUM_W-1:0] page;
    logic [WORD_IDX_W-1:0] word_idx;
    logic [BIT_OFS_W-1:0]  bit_ofs;
    logic [WORDS_W-1:0]    words;
    logic [CFG_W-1:0]      res;
    logic [CFG_W-1:0]      init_free;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC_REF,
    ST_RMW
  } back_state_e;

endpackage
`default_nettype wire

// ----- rtl/pfa_fifo.sv -----
// Small first-in first-out queue of a generic item type.
`default_nettype none
module pfa_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = pfa_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (32'(count_q) == 32'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == 32'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == 32'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pfa_front.sv -----
// Front end: configuration registers and classification of requests into commands.
`default_nettype none
module pfa_front #(
  parameter int MAX_PAGES     = pfa_pkg::DEF_MAX_PAGES,
  parameter int MAP_WORD_BITS = pfa_pkg::DEF_MAP_WORD_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pfa_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire pfa_pkg::req_t                  req_i,
  output pfa_pkg::cmd_t                       cmd_o
);

  // Division by the word size as a multiply by its reciprocal, exact for
  // dividends of CFG_W bits.
  localparam int DIV_SHIFT = pfa_pkg::CFG_W + $clog2(MAP_WORD_BITS);
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  logic [pfa_pkg::CFG_W-1:0] reserved_q;
  logic [pfa_pkg::CFG_W-1:0] total_q;
  logic [pfa_pkg::CFG_W-1:0] limit;
  logic [pfa_pkg::CFG_W-1:0] res_clamp;
  logic [31:0]               words_prod;
  logic [31:0]               page_prod;
  logic [31:0]               page_quot;
  logic [31:0]               page_rem;
  logic                      in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= pfa_pkg::CFG_RESERVED_RESET;
      total_q    <= pfa_pkg::CFG_TOTAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfa_pkg::CFG_RESERVED_PAGES: reserved_q <= cfg_data_i;
        pfa_pkg::CFG_TOTAL_PAGES:    total_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    limit     = (32'(total_q) > 32'(MAX_PAGES)) ? pfa_pkg::CFG_W'(MAX_PAGES) : total_q;
    res_clamp = (32'(reserved_q) > 32'(MAX_PAGES)) ? pfa_pkg::CFG_W'(MAX_PAGES)
                                                  : reserved_q;
    words_prod = 32'(limit) * 32'(DIV_MUL);
    page_prod  = 32'(req_i.page_number) * 32'(DIV_MUL);
    page_quot  = page_prod >> DIV_SHIFT;
    page_rem   = 32'(req_i.page_number) - page_quot * 32'(MAP_WORD_BITS);
    in_range   = (32'(req_i.page_number) < 32'(limit));

    cmd_o.page      = req_i.page_number;
    cmd_o.word_idx  = pfa_pkg::WORD_IDX_W'(page_quot);
    cmd_o.bit_ofs   = pfa_pkg::BIT_OFS_W'(page_rem);
    cmd_o.words     = pfa_pkg::WORDS_W'(words_prod >> DIV_SHIFT);
    cmd_o.res       = res_clamp;
    cmd_o.init_free = (limit > reserved_q) ? (limit - reserved_q) : '0;

    case (req_i.req_type)
      pfa_pkg::REQ_INIT:  cmd_o.op = pfa_pkg::CMD_INIT;
      pfa_pkg::REQ_ALLOC: cmd_o.op = pfa_pkg::CMD_ALLOC;
      pfa_pkg::REQ_INC:   cmd_o.op = in_range ? pfa_pkg::CMD_INC : pfa_pkg::CMD_RANGE;
      pfa_pkg::REQ_DEC:   cmd_o.op = in_range ? pfa_pkg::CMD_DEC : pfa_pkg::CMD_RANGE;
      default:            cmd_o.op = pfa_pkg::CMD_RANGE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pfa_back.sv -----
// Back end: bitmap and reference count memories, free counter and request sequencer.
`default_nettype none
module pfa_back #(
  parameter int MAX_PAGES     = pfa_pkg::DEF_MAX_PAGES,
  parameter int MAP_WORD_BITS = pfa_pkg::DEF_MAP_WORD_BITS,
  parameter int REF_BITS      = pfa_pkg::DEF_REF_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pfa_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output pfa_pkg::rsp_t      rsp_o,
  output logic               rsp_push_o,
  input  wire logic          rsp_full_i
);

  localparam int NUM_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW        = $clog2(MAX_PAGES);
  localparam int BW        = $clog2(MAP_WORD_BITS);
  localparam int FCW       = $clog2(MAX_PAGES + 1);

  pfa_pkg::back_state_e state_q, state_d;

  logic [PW-1:0]              cnt_q, cnt_d;
  logic [pfa_pkg::CFG_W-1:0]  res_q, res_d;
  logic                       reply_q, reply_d;
  logic [WIW-1:0]             idx_q, idx_d;
  logic [pfa_pkg::WORDS_W-1:0] words_q, words_d;
  logic [PW-1:0]              pg_q, pg_d;
  logic [FCW-1:0]             free_q, free_d;
  pfa_pkg::cmd_t              cmd_q, cmd_d;

  // Memories with registered read data.
  logic [REF_BITS-1:0]      ref_mem [MAX_PAGES];
  logic [MAP_WORD_BITS-1:0] map_mem [NUM_WORDS];
  logic [REF_BITS-1:0]      ref_rd_q;
  logic [MAP_WORD_BITS-1:0] map_rd_q;

  logic                     ref_we;
  logic [PW-1:0]            ref_waddr, ref_raddr;
  logic [REF_BITS-1:0]      ref_wdata;
  logic                     map_we;
  logic [WIW-1:0]           map_waddr, map_raddr;
  logic [MAP_WORD_BITS-1:0] map_wdata;

  logic [31:0]              base32;
  logic [31:0]              res32;
  logic [BW-1:0]            fill_n;
  logic [MAP_WORD_BITS-1:0] sweep_mask;
  logic [MAP_WORD_BITS-1:0] lz_onehot;
  logic [BW-1:0]            lz_idx;
  logic                     map_full;
  logic [31:0]              pg32;
  logic [REF_BITS-1:0]      ref_inc;
  logic [REF_BITS-1:0]      ref_dec;
  logic [FCW-1:0]           free_dec;
  logic [FCW-1:0]           free_inc;
  logic [BW-1:0]            bit_sel;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    ref_rd_q <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  // Mask of reserved pages for the map word that the clearing pass is at.
  always_comb begin
    base32 = 32'(cnt_q) * 32'(MAP_WORD_BITS);
    res32  = 32'(res_q);
    fill_n = BW'(res32 - base32);
    if (res32 >= base32 + 32'(MAP_WORD_BITS)) begin
      sweep_mask = '1;
    end else if (res32 <= base32) begin
      sweep_mask = '0;
    end else begin
      sweep_mask = ~({MAP_WORD_BITS{1'b1}} << fill_n);
    end
  end

  // Lowest clear bit of the map word just read.
  always_comb begin
    lz_onehot = ~map_rd_q & (map_rd_q + MAP_WORD_BITS'(1));
    lz_idx    = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (lz_onehot[b]) begin
        lz_idx = lz_idx | BW'(b);
      end
    end
    map_full = &map_rd_q;
    pg32     = 32'(idx_q) * 32'(MAP_WORD_BITS) + 32'(lz_idx);
  end

  assign ref_inc  = (&ref_rd_q) ? ref_rd_q : ref_rd_q + REF_BITS'(1);
  assign ref_dec  = ref_rd_q - REF_BITS'(1);
  assign free_dec = free_q - FCW'(1);
  assign free_inc = (32'(free_q) < 32'(MAX_PAGES)) ? free_q + FCW'(1) : free_q;
  assign bit_sel  = BW'(cmd_q.bit_ofs);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    reply_d = reply_q;
    idx_d   = idx_q;
    words_d = words_q;
    pg_d    = pg_q;
    free_d  = free_q;
    cmd_d   = cmd_q;

    cmd_pop_o        = 1'b0;
    rsp_push_o       = 1'b0;
    rsp_o.status     = pfa_pkg::STATUS_OK;
    rsp_o.alloc_page = '0;
    rsp_o.ref_count  = '0;
    rsp_o.free_pages = pfa_pkg::FREE_OUT_W'(32'(free_q));

    ref_we    = 1'b0;
    ref_waddr = cnt_q;
    ref_wdata = '0;
    ref_raddr = PW'(cmd_i.page);
    map_we    = 1'b0;
    map_waddr = WIW'(cnt_q);
    map_wdata = sweep_mask;
    map_raddr = WIW'(cmd_i.word_idx);

    case (state_q)
      pfa_pkg::ST_SWEEP: begin
        ref_we = 1'b1;
        if (32'(cnt_q) < 32'(NUM_WORDS)) begin
          map_we = 1'b1;
        end
        if (32'(cnt_q) == 32'(MAX_PAGES - 1)) begin
          state_d    = pfa_pkg::ST_IDLE;
          cnt_d      = '0;
          rsp_push_o = reply_q;
          reply_d    = 1'b0;
        end else begin
          cnt_d = cnt_q + PW'(1);
        end
      end

      pfa_pkg::ST_IDLE: begin
        if (cmd_valid_i && !rsp_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            pfa_pkg::CMD_INIT: begin
              free_d  = FCW'(cmd_i.init_free);
              res_d   = cmd_i.res;
              cnt_d   = '0;
              reply_d = 1'b1;
              state_d = pfa_pkg::ST_SWEEP;
            end
            pfa_pkg::CMD_ALLOC: begin
              if (free_q == '0 || cmd_i.words == '0) begin
                rsp_push_o   = 1'b1;
                rsp_o.status = pfa_pkg::STATUS_OOM;
              end else begin
                idx_d     = '0;
                words_d   = cmd_i.words;
                map_raddr = '0;
                state_d   = pfa_pkg::ST_SCAN;
              end
            end
            pfa_pkg::CMD_INC, pfa_pkg::CMD_DEC: begin
              state_d = pfa_pkg::ST_RMW;
            end
            default: begin
              rsp_push_o   = 1'b1;
              rsp_o.status = pfa_pkg::STATUS_RANGE;
            end
          endcase
        end
      end

      pfa_pkg::ST_SCAN: begin
        if (!map_full) begin
          // Only the first word with a clear bit is looked at.
          if (pg32 >= 32'(MAX_PAGES)) begin
            rsp_push_o   = 1'b1;
            rsp_o.status = pfa_pkg::STATUS_OOM;
            state_d      = pfa_pkg::ST_IDLE;
          end else begin
            map_we    = 1'b1;
            map_waddr = idx_q;
            map_wdata = map_rd_q | lz_onehot;
            ref_raddr = PW'(pg32);
            pg_d      = PW'(pg32);
            state_d   = pfa_pkg::ST_ALLOC_REF;
          end
        end else if (32'(idx_q) + 32'd1 == 32'(words_q)) begin
          rsp_push_o   = 1'b1;
          rsp_o.status = pfa_pkg::STATUS_OOM;
          state_d      = pfa_pkg::ST_IDLE;
        end else begin
          idx_d     = idx_q + WIW'(1);
          map_raddr = idx_q + WIW'(1);
        end
      end

      pfa_pkg::ST_ALLOC_REF: begin
        ref_we           = 1'b1;
        ref_waddr        = pg_q;
        ref_wdata        = ref_inc;
        free_d           = free_dec;
        rsp_push_o       = 1'b1;
        rsp_o.alloc_page = pfa_pkg::PAGE_NUM_W'(32'(pg_q));
        rsp_o.ref_count  = pfa_pkg::REF_OUT_W'(32'(ref_inc));
        rsp_o.free_pages = pfa_pkg::FREE_OUT_W'(32'(free_dec));
        state_d          = pfa_pkg::ST_IDLE;
      end

      pfa_pkg::ST_RMW: begin
        ref_waddr  = PW'(cmd_q.page);
        map_waddr  = WIW'(cmd_q.word_idx);
        map_wdata  = map_rd_q & ~(MAP_WORD_BITS'(1) << bit_sel);
        rsp_push_o = 1'b1;
        state_d    = pfa_pkg::ST_IDLE;
        if (cmd_q.op == pfa_pkg::CMD_INC) begin
          ref_we          = 1'b1;
          ref_wdata       = ref_inc;
          rsp_o.ref_count = pfa_pkg::REF_OUT_W'(32'(ref_inc));
        end else if (ref_rd_q != '0) begin
          ref_we          = 1'b1;
          ref_wdata       = ref_dec;
          rsp_o.ref_count = pfa_pkg::REF_OUT_W'(32'(ref_dec));
          // The page goes back to the pool only if its map bit was still set.
          if (ref_dec == '0 && map_rd_q[bit_sel]) begin
            map_we           = 1'b1;
            free_d           = free_inc;
            rsp_o.free_pages = pfa_pkg::FREE_OUT_W'(32'(free_inc));
          end
        end
      end

      default: begin
        state_d = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_SWEEP;
      cnt_q   <= '0;
      res_q   <= '0;
      reply_q <= 1'b0;
      idx_q   <= '0;
      words_q <= '0;
      free_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
      reply_q <= reply_d;
      idx_q   <= idx_d;
      words_q <= words_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q  <= pg_d;
    cmd_q <= cmd_d;
  end

endmodule
`default_nettype wire

// ----- rtl/page_frame_allocator_refcount_top.sv -----
// Top level of the page frame allocator with reference counts.
//
//  channel   direction  handshake                 payload
//  request   in         push / full               req_i  (req_type, page_number)
//  result    out        empty / pop               rsp_o  (status, alloc_page,
//                                                         ref_count, free_pages)
//  config    in         cfg_we_i, cfg_idx_i       cfg_data_i
//
// Requests are classified on entry and wait in a short command queue; results wait in a
// result queue. The sequencer takes one command at a time: inc_ref and dec_ref read the
// count and update it, a granted alloc reads map words until one has a clear bit and
// then writes the count, out-of-range and early out-of-memory answers are given from idle,
// and init runs the clearing pass. After reset that pass runs before any command is done;
// requests queue up meanwhile, and a full result queue holds the sequencer in idle.
`default_nettype none
module page_frame_allocator_refcount_top #(
  parameter int MAX_PAGES     = pfa_pkg::DEF_MAX_PAGES,
  parameter int MAP_WORD_BITS = pfa_pkg::DEF_MAP_WORD_BITS,
  parameter int REF_BITS      = pfa_pkg::DEF_REF_BITS,
  parameter int QUEUE_DEPTH   = pfa_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire pfa_pkg::req_t                 req_i,
  output logic                               empty,
  input  wire logic                          pop,
  output pfa_pkg::rsp_t                      rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pfa_pkg::CFG_W-1:0]     cfg_data_i
);

  pfa_pkg::cmd_t cmd_in;
  pfa_pkg::cmd_t cmd_out;
  logic          cmd_empty;
  logic          cmd_pop;
  pfa_pkg::rsp_t rsp_in;
  logic          rsp_push;
  logic          rsp_full;

  pfa_front #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_o      (cmd_in)
  );

  pfa_fifo #(
    .T     (pfa_pkg::cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  pfa_back #(
    .MAX_PAGES     (MAX_PAGES),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .REF_BITS      (REF_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_in),
    .rsp_push_o  (rsp_push),
    .rsp_full_i  (rsp_full)
  );

  pfa_fifo #(
    .T     (pfa_pkg::rsp_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_rsp_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

  // The sequencer reserves result space before it starts a command.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push |-> !rsp_full)
    else $error("result pushed into a full result queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  a_range_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_push && rsp_in.status == pfa_pkg::STATUS_RANGE) |->
      (rsp_in.alloc_page == '0 && rsp_in.ref_count == '0))
    else $error("out-of-range result carries a page or a count");

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push |-> (32'(rsp_in.free_pages) <= 32'(MAX_PAGES)))
    else $error("free page count above the store size");

endmodule
`default_nettype wire
